// File: rtl/cyclic_dosing_timer_core_macros.svh
// Assertion macros for the cyclic dosing timer core.
// Depends on nothing; included by the files that carry assertions.
`ifndef CYCLIC_DOSING_TIMER_CORE_MACROS_SVH
`define CYCLIC_DOSING_TIMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cdt_pkg.sv
// Shared types and constants of the cyclic dosing timer core.
// Depends on nothing; used by the interfaces and all modules.
package cdt_pkg;

  localparam int unsigned BATCH_W = 20;
  localparam int unsigned SEC_W   = 16;
  localparam int unsigned VOL_W   = 30;
  localparam int unsigned ALU_W   = VOL_W + 1;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = BATCH_W;

  localparam int unsigned MILLI_PER_LITRE = 1000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_VOLUME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_LITRES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOSE_SECONDS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_SECONDS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY    = 3'd4;

  // Pump status codes.
  localparam logic [STAT_W-1:0] PUMP_OFF  = 2'd0;
  localparam logic [STAT_W-1:0] PUMP_ON   = 2'd1;
  localparam logic [STAT_W-1:0] PUMP_WAIT = 2'd2;

  typedef struct packed {
    logic [BATCH_W-1:0] batch_volume;
    logic               volume_in_litres;
    logic [SEC_W-1:0]   dose_seconds;
    logic [SEC_W-1:0]   cycle_seconds;
    logic [SEC_W-1:0]   start_delay_seconds;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    AR_IDLE,
    AR_DIV,
    AR_MUL,
    AR_SUB
  } arith_state_e;

  // Batch volume converted to millilitres.
  function automatic logic [VOL_W-1:0] batch_ml(input cfg_t cfg);
    logic [VOL_W-1:0] base;
    base = VOL_W'(cfg.batch_volume);
    if (cfg.volume_in_litres) begin
      batch_ml = base * VOL_W'(MILLI_PER_LITRE);
    end else begin
      batch_ml = base;
    end
  endfunction

endpackage

// File: rtl/cdt_if.sv
// Valid/ready channel interfaces of the cyclic dosing timer core.
// Depends on cdt_pkg for field widths.
interface cdt_item_if;
  logic                      valid;
  logic                      ready;
  logic                      mode_cyclic;
  logic                      pump_enabled;
  logic                      remote_allows_run;
  logic [cdt_pkg::STAT_W-1:0] pump_status_in;

  modport source (output valid, output mode_cyclic, output pump_enabled,
                  output remote_allows_run, output pump_status_in, input ready);
  modport sink   (input valid, input mode_cyclic, input pump_enabled,
                  input remote_allows_run, input pump_status_in, output ready);
endinterface

interface cdt_result_if;
  logic                       valid;
  logic                       ready;
  logic                       signal_wait;
  logic                       signal_run;
  logic [cdt_pkg::STAT_W-1:0] pump_status_out;
  logic                       dosing_started;
  logic [cdt_pkg::VOL_W-1:0]  volume_left_ml;
  logic [cdt_pkg::SEC_W-1:0]  cycle_seconds_left;

  modport source (output valid, output signal_wait, output signal_run,
                  output pump_status_out, output dosing_started,
                  output volume_left_ml, output cycle_seconds_left, input ready);
  modport sink   (input valid, input signal_wait, input signal_run,
                  input pump_status_out, input dosing_started,
                  input volume_left_ml, input cycle_seconds_left, output ready);
endinterface

interface cdt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cdt_pkg::CFG_IDX_W-1:0]  index;
  logic [cdt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/cdt_cfg_regs.sv
// Configuration register file of the cyclic dosing timer core.
// Depends on cdt_pkg and cdt_cfg_if.
module cdt_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  cdt_cfg_if.sink       cfg_i,
  output cdt_pkg::cfg_t cfg_o
);

  cdt_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        cdt_pkg::CFG_BATCH_VOLUME: begin
          cfg_d.batch_volume = cfg_i.data[cdt_pkg::BATCH_W-1:0];
        end
        cdt_pkg::CFG_VOLUME_LITRES: begin
          cfg_d.volume_in_litres = cfg_i.data[0];
        end
        cdt_pkg::CFG_DOSE_SECONDS: begin
          cfg_d.dose_seconds = cfg_i.data[cdt_pkg::SEC_W-1:0];
        end
        cdt_pkg::CFG_CYCLE_SECONDS: begin
          cfg_d.cycle_seconds = cfg_i.data[cdt_pkg::SEC_W-1:0];
        end
        cdt_pkg::CFG_START_DELAY: begin
          cfg_d.start_delay_seconds = cfg_i.data[cdt_pkg::SEC_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.batch_volume        <= '0;
      cfg_q.volume_in_litres    <= 1'b0;
      cfg_q.dose_seconds        <= cdt_pkg::SEC_W'(1);
      cfg_q.cycle_seconds       <= '0;
      cfg_q.start_delay_seconds <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/cdt_arith.sv
// Iterative remaining-volume unit: restoring divide, shift-add multiply and a
// final floored subtract, all on one shared adder. Depends on cdt_pkg.
module cdt_arith #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cdt_pkg::VOL_W-1:0]   vol_i,
  input  logic [cdt_pkg::SEC_W-1:0]   div_i,
  input  logic [COUNT_BITS-1:0]       count_i,
  output logic                        done_o,
  output logic [cdt_pkg::VOL_W-1:0]   vol_left_o
);

  localparam int unsigned CW        = COUNT_BITS;
  localparam int unsigned VW        = cdt_pkg::VOL_W;
  localparam int unsigned SW        = cdt_pkg::SEC_W;
  localparam int unsigned AW        = cdt_pkg::ALU_W;
  localparam int unsigned PROD_W    = AW + CW;
  localparam int unsigned STEPS_MAX = (VW > CW) ? VW : CW;
  localparam int unsigned STEP_W    = $clog2(STEPS_MAX);

  cdt_pkg::arith_state_e state_q, state_d;
  logic [STEP_W-1:0]     cnt_q, cnt_d;
  logic [SW-1:0]         rem_q, rem_d;
  logic [VW-1:0]         quo_q, quo_d;
  logic [PROD_W-1:0]     prod_q, prod_d;

  // Shared adder/subtractor.
  logic [AW-1:0] op_a, op_b;
  logic          op_sub;
  logic [AW:0]   sum;
  logic          carry;

  logic [SW:0]   trial;
  logic [AW-1:0] hi_next;

  assign sum   = {1'b0, op_a} + {1'b0, op_b ^ {AW{op_sub}}} + {{AW{1'b0}}, op_sub};
  assign carry = sum[AW];
  assign trial = {rem_q, quo_q[VW-1]};

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (state_q)
      cdt_pkg::AR_DIV: begin
        op_a   = AW'(trial);
        op_b   = AW'(div_i);
        op_sub = 1'b1;
      end
      cdt_pkg::AR_MUL: begin
        op_a   = prod_q[PROD_W-1:CW];
        op_b   = AW'(quo_q);
        op_sub = 1'b0;
      end
      cdt_pkg::AR_SUB: begin
        op_a   = AW'(vol_i);
        op_b   = AW'(prod_q[VW-1:0]);
        op_sub = 1'b1;
      end
      default: begin
        op_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    prod_d  = prod_q;
    hi_next = prod_q[0] ? sum[AW-1:0] : prod_q[PROD_W-1:CW];
    case (state_q)
      cdt_pkg::AR_IDLE: begin
        if (start_i) begin
          rem_d   = '0;
          quo_d   = vol_i;
          prod_d  = {{AW{1'b0}}, count_i};
          cnt_d   = STEP_W'(VW - 1);
          state_d = cdt_pkg::AR_DIV;
        end
      end
      cdt_pkg::AR_DIV: begin
        rem_d = carry ? sum[SW-1:0] : trial[SW-1:0];
        quo_d = {quo_q[VW-2:0], carry};
        if (cnt_q == '0) begin
          cnt_d   = STEP_W'(CW - 1);
          state_d = cdt_pkg::AR_MUL;
        end else begin
          cnt_d = cnt_q - STEP_W'(1);
        end
      end
      cdt_pkg::AR_MUL: begin
        prod_d = {1'b0, hi_next, prod_q[CW-1:1]};
        if (cnt_q == '0) begin
          state_d = cdt_pkg::AR_SUB;
        end else begin
          cnt_d = cnt_q - STEP_W'(1);
        end
      end
      cdt_pkg::AR_SUB: begin
        state_d = cdt_pkg::AR_IDLE;
      end
      default: begin
        state_d = cdt_pkg::AR_IDLE;
      end
    endcase
  end

  // The used volume only counts when it lies below the batch volume.
  assign done_o     = (state_q == cdt_pkg::AR_SUB);
  assign vol_left_o = (carry && (prod_q[PROD_W-1:VW] == '0)) ? sum[VW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdt_pkg::AR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    prod_q <= prod_d;
  end

endmodule

// File: rtl/cyclic_dosing_timer_core.sv
// Cyclic dosing timer core: one result transaction per tick transaction.
// A dosing tick runs the bit-serial divide and multiply of cdt_arith before its
// result is loaded; any other tick goes straight to the output register. The next
// tick is accepted in the cycle after a result loads, so no new tick is taken
// while the last one is still in flight.
// rst_ni clears the timer state and output valid and resets the configuration registers.
`include "cyclic_dosing_timer_core_macros.svh"

module cyclic_dosing_timer_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cdt_item_if.sink     item_i,
  cdt_result_if.source result_o,
  cdt_cfg_if.sink      cfg_i
);

  localparam int unsigned CW    = COUNT_BITS;
  localparam int unsigned SW    = cdt_pkg::SEC_W;
  localparam int unsigned VW    = cdt_pkg::VOL_W;
  localparam int unsigned CMP_W = (CW > SW) ? CW : SW;

  // Configuration registers.
  cdt_pkg::cfg_t    cfg;
  logic [VW-1:0]    batch_ml;

  cdt_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign batch_ml = cdt_pkg::batch_ml(cfg);

  // Sequencer state and timer state. The timer state is committed in the
  // accept cycle; only the dosing volume waits for the arithmetic unit.
  cdt_pkg::top_state_e state_q, state_d;

  logic                      started_q, started_d;
  logic [CW-1:0]             delay_q, delay_d;
  logic [CW-1:0]             dose_q, dose_d;
  logic [VW-1:0]             vol_left_q, vol_left_d;
  logic [SW-1:0]             cycle_left_q, cycle_left_d;

  // Per-tick flags that wait for the output register.
  logic                      res_wait_q, res_wait_d;
  logic                      res_run_q, res_run_d;
  logic [cdt_pkg::STAT_W-1:0] res_status_q, res_status_d;

  // Output register.
  logic                      out_valid_q, out_valid_d;
  logic                      out_wait_q, out_run_q, out_started_q;
  logic [cdt_pkg::STAT_W-1:0] out_status_q;
  logic [VW-1:0]             out_vol_q;
  logic [SW-1:0]             out_cycle_q;
  logic                      out_load;

  // Tick evaluation helpers.
  logic                      accept;
  logic                      active;
  logic [CW-1:0]             delay_inc;
  logic [CW-1:0]             dose_inc;
  logic [CW-1:0]             dose_new;
  logic [CMP_W-1:0]          cycle_diff;
  logic                      dosing;
  logic                      arith_start;
  logic                      arith_done;
  logic [VW-1:0]             arith_vol;

  assign accept    = item_i.valid && item_i.ready;
  assign active    = item_i.mode_cyclic && item_i.pump_enabled && item_i.remote_allows_run;
  assign delay_inc = delay_q + CW'(1);
  assign dose_inc  = dose_q + CW'(1);
  // The pump is dosing while the seconds counted in this cycle stay below the
  // dosing time. A dosing time of zero never doses.
  assign dosing    = CMP_W'(dose_inc) < CMP_W'(cfg.dose_seconds);
  // The counter restarts once it reaches the cycle length.
  assign dose_new  = (CMP_W'(dose_inc) >= CMP_W'(cfg.cycle_seconds)) ? '0 : dose_inc;
  assign cycle_diff = CMP_W'(cfg.cycle_seconds) - CMP_W'(dose_new);

  assign arith_start = accept && active && started_q && dosing;

  // The volume still to dose is the batch volume less the whole millilitres
  // per second times the elapsed dosing seconds, floored at zero.
  cdt_arith #(
    .COUNT_BITS (COUNT_BITS)
  ) u_arith (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (arith_start),
    .vol_i      (batch_ml),
    .div_i      (cfg.dose_seconds),
    .count_i    (dose_inc),
    .done_o     (arith_done),
    .vol_left_o (arith_vol)
  );

  assign item_i.ready = (state_q == cdt_pkg::ST_IDLE);
  assign out_load     = (state_q == cdt_pkg::ST_OUT) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d      = state_q;
    started_d    = started_q;
    delay_d      = delay_q;
    dose_d       = dose_q;
    vol_left_d   = vol_left_q;
    cycle_left_d = cycle_left_q;
    res_wait_d   = res_wait_q;
    res_run_d    = res_run_q;
    res_status_d = res_status_q;
    case (state_q)
      cdt_pkg::ST_IDLE: begin
        if (accept) begin
          res_wait_d   = 1'b0;
          res_run_d    = 1'b0;
          res_status_d = item_i.pump_status_in;
          state_d      = cdt_pkg::ST_OUT;
          if (!active) begin
            // An inactive tick leaves the timer untouched.
            res_run_d = 1'b1;
          end else if (!started_q) begin
            // Start delay: count towards the delay and wind the cycle down.
            res_wait_d = 1'b1;
            if (CMP_W'(delay_inc) >= CMP_W'(cfg.start_delay_seconds)) begin
              started_d = 1'b1;
              delay_d   = '0;
              res_run_d = 1'b1;
            end else begin
              delay_d = delay_inc;
            end
            if (cycle_left_q != '0) begin
              cycle_left_d = cycle_left_q - SW'(1);
            end
          end else begin
            // Cyclic phase: a waiting pump is switched on while dosing, and
            // the full batch is reloaded outside the dosing window.
            if (dosing) begin
              res_run_d = 1'b1;
              if (item_i.pump_status_in == cdt_pkg::PUMP_WAIT) begin
                res_status_d = cdt_pkg::PUMP_ON;
              end
              state_d = cdt_pkg::ST_CALC;
            end else begin
              res_wait_d = 1'b1;
              vol_left_d = batch_ml;
            end
            dose_d = dose_new;
            if (CMP_W'(cfg.cycle_seconds) >= CMP_W'(dose_new)) begin
              cycle_left_d = cycle_diff[SW-1:0];
            end
          end
        end
      end
      cdt_pkg::ST_CALC: begin
        if (arith_done) begin
          vol_left_d = arith_vol;
          state_d    = cdt_pkg::ST_OUT;
        end
      end
      cdt_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = cdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cdt_pkg::ST_IDLE;
      started_q    <= 1'b0;
      delay_q      <= '0;
      dose_q       <= '0;
      vol_left_q   <= '0;
      cycle_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      started_q    <= started_d;
      delay_q      <= delay_d;
      dose_q       <= dose_d;
      vol_left_q   <= vol_left_d;
      cycle_left_q <= cycle_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_wait_q   <= res_wait_d;
    res_run_q    <= res_run_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_wait_q    <= res_wait_q;
      out_run_q     <= res_run_q;
      out_status_q  <= res_status_q;
      out_started_q <= started_q;
      out_vol_q     <= vol_left_q;
      out_cycle_q   <= cycle_left_q;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.signal_wait        = out_wait_q;
  assign result_o.signal_run         = out_run_q;
  assign result_o.pump_status_out    = out_status_q;
  assign result_o.dosing_started     = out_started_q;
  assign result_o.volume_left_ml     = out_vol_q;
  assign result_o.cycle_seconds_left = out_cycle_q;

  // Once dosing has started it stays started until reset.
  `CDT_ASSERT_IMP(a_started_sticky, clk_i, rst_ni, 1'b1, !$fell(started_q), "started flag cleared")
  // The arithmetic unit only finishes while the sequencer waits for it.
  `CDT_ASSERT_IMP(a_done_in_calc, clk_i, rst_ni, arith_done, state_q == cdt_pkg::ST_CALC, "stray arithmetic completion")
  // Every accepted tick moves the sequencer towards a result.
  `CDT_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, state_q != cdt_pkg::ST_IDLE, "tick accepted without result")

endmodule
